### sv/bfq_pkg.sv
`default_nettype none
package bfq_pkg;

    localparam int VALUE_W   = 64;
    localparam int EXP_W     = 11;
    localparam int FRAC_W    = 52;
    localparam int SUM_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    localparam logic [EXP_W-1:0] EXP_MIDPOINT = 11'd1023;
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7ff;
    localparam logic [EXP_W-1:0] FIXED_CENTER = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] CFG_EXP_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_MODE = 2'd2;

    localparam logic [1:0] MODE_AVERAGE = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_BOUNDS,
        ST_EMIT
    } bfq_state_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_status_t;

endpackage
`default_nettype wire

### sv/block_exponent_float_quantizer_unit.sv
`default_nettype none
// block floating-point quantizer for ieee double words
// input stream: s_tdata carries one double, s_tlast closes a block; a block also
// closes once BLOCK_CAPACITY elements are held
// output stream: one transaction per buffered element, in arrival order, with the
// fraction cut and, in modes 0 and 1, the exponent clamped around a centre; m_tlast
// marks the last element of the block and m_tdata also carries the centre exponent used
// configuration: cfg_we writes cfg_data into register cfg_index (0 exponent width,
// 1 fraction bits, 2 centre mode); write only while the block is idle
// flow: elements are loaded one per cycle while s_tready is high and emitted one per
// cycle while the receiver does not stall; after the closing transaction a block
// passes through the divider start, serial divider wait and bounds states in average
// mode, and the bounds state alone in the other modes, before emission starts;
// elements sit in a row of cells that shifts towards the head cell
// s_tready is low from block end until the last result has entered the output
// register; a stalled receiver holds the output register and so halts the row
// reset empties the row, clears the sums and restores the register defaults
module block_exponent_float_quantizer_unit
    import bfq_pkg::*;
#(
    parameter int BLOCK_CAPACITY = 64
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // value_bits
    input  wire logic                 s_tlast,   // block_last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [79:0]          m_tdata,   // result_bits, center_exponent, zero pad
    output logic                      m_tlast,   // last_out
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(BLOCK_CAPACITY + 1);

    // configuration registers
    logic [3:0] exp_bits_reg;
    logic [5:0] frac_bits_reg;
    logic [1:0] mode_reg;

    bfq_state_t state_reg, state_next;

    // block accumulation
    logic [CNT_W-1:0]        cnt_reg,   cnt_next;
    logic [CNT_W-1:0]        ncnt_reg,  ncnt_next;
    logic signed [SUM_W-1:0] sum_reg,   sum_next;
    logic [CNT_W-1:0]        left_reg,  left_next;

    // per-block quantizer settings
    logic             clamp_reg,  clamp_next;
    logic [EXP_W-1:0] center_reg, center_next;
    logic [EXP_W-1:0] lo_reg,     lo_next;
    logic [EXP_W-1:0] hi_reg,     hi_next;
    logic [FRAC_W-1:0] fmask_reg, fmask_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic              out_last_reg,  out_last_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;
    logic [EXP_W-1:0]  out_center_reg, out_center_next;

    logic load_fire;
    logic emit_fire;
    logic div_start;
    logic [SUM_W-1:0] div_dividend;
    div_status_t div_status;

    logic [VALUE_W-1:0] cell_q    [BLOCK_CAPACITY];
    logic [VALUE_W-1:0] cell_next [BLOCK_CAPACITY];

    assign load_fire = s_tvalid && s_tready;
    assign emit_fire = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);
    assign s_tready  = (state_reg == ST_LOAD);

    // row of element cells, head is cell 0
    for (genvar i = 0; i < BLOCK_CAPACITY; i++)
    begin : g_cell
        if (i == BLOCK_CAPACITY - 1)
        begin : g_tail
            assign cell_next[i] = '0;
        end
        else
        begin : g_body
            assign cell_next[i] = cell_q[i+1];
        end

        bfq_cell #(
            .W (VALUE_W)
        ) u_cell (
            .clk       (clk),
            .load_en   (load_fire && (cnt_reg == CNT_W'(i))),
            .shift_en  (emit_fire),
            .load_data (s_tdata),
            .next_data (cell_next[i]),
            .data      (cell_q[i])
        );
    end

    // magnitude of the exponent sum into the divider
    assign div_dividend = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    bfq_div #(
        .DIVISOR_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (ncnt_reg),
        .status   (div_status)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_bits_reg  <= 4'd8;
            frac_bits_reg <= 6'd23;
            mode_reg      <= MODE_AVERAGE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_EXP_BITS:    exp_bits_reg  <= cfg_data[3:0];
                CFG_FRAC_BITS:   frac_bits_reg <= cfg_data;
                CFG_CENTER_MODE: mode_reg      <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        logic [EXP_W-1:0]        in_exp;
        logic [3:0]              k_eff;
        logic [5:0]              f_eff;
        logic [EXP_W-1:0]        half;
        logic [EXP_W-1:0]        avg_mag;
        logic signed [EXP_W:0]   avg_s;
        logic signed [EXP_W:0]   center_s;
        logic signed [EXP_W+1:0] lo_s;
        logic signed [EXP_W+1:0] hi_s;
        logic [VALUE_W-1:0]      w;
        logic [EXP_W-1:0]        x;
        logic [EXP_W-1:0]        x_cl;

        in_exp   = s_tdata[62:52];
        k_eff    = (exp_bits_reg == 4'd0) ? 4'd1 :
                   ((exp_bits_reg > 4'd11) ? 4'd11 : exp_bits_reg);
        f_eff    = (frac_bits_reg > 6'd52) ? 6'd52 : frac_bits_reg;
        half     = EXP_W'(1) << (k_eff - 4'd1);
        avg_mag  = (ncnt_reg == '0) ? '0 : div_status.quotient[EXP_W-1:0];
        avg_s    = sum_reg[SUM_W-1] ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});

        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ncnt_next       = ncnt_reg;
        sum_next        = sum_reg;
        left_next       = left_reg;
        clamp_next      = clamp_reg;
        center_next     = center_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        fmask_next      = fmask_reg;
        div_start       = 1'b0;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_data_next   = out_data_reg;
        out_center_next = out_center_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        // centre choice and clamp window
        if (mode_reg == MODE_AVERAGE)
        begin
            center_s = $signed({1'b0, EXP_MIDPOINT}) + avg_s;
        end
        else if (mode_reg == MODE_FIXED)
        begin
            center_s = $signed({1'b0, FIXED_CENTER});
        end
        else
        begin
            center_s = '0;
        end
        lo_s = $signed({center_s[EXP_W], center_s}) - $signed({2'b00, half});
        hi_s = $signed({center_s[EXP_W], center_s}) + $signed({2'b00, half})
               - (EXP_W+2)'(1);

        // quantize the head element
        w    = cell_q[0] & {1'b1, EXP_ALL_ONES, fmask_reg};
        x    = w[62:52];
        x_cl = (x > hi_reg) ? hi_reg : x;
        x_cl = (x_cl < lo_reg) ? lo_reg : x_cl;

        case (state_reg)
            ST_LOAD:
            begin
                if (load_fire)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    if (in_exp != '0 && in_exp != EXP_ALL_ONES)
                    begin
                        sum_next  = sum_reg + $signed(SUM_W'(in_exp))
                                    - $signed(SUM_W'(EXP_MIDPOINT));
                        ncnt_next = ncnt_reg + CNT_W'(1);
                    end
                    if (s_tlast || cnt_reg == CNT_W'(BLOCK_CAPACITY - 1))
                    begin
                        left_next  = cnt_reg + CNT_W'(1);
                        cnt_next   = '0;
                        state_next = (mode_reg == MODE_AVERAGE) ? ST_DIV_START : ST_BOUNDS;
                    end
                end
            end
            ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_status.done)
                begin
                    state_next = ST_BOUNDS;
                end
            end
            ST_BOUNDS:
            begin
                clamp_next  = (mode_reg == MODE_AVERAGE) || (mode_reg == MODE_FIXED);
                center_next = center_s[EXP_W-1:0];
                lo_next     = lo_s[EXP_W+1] ? '0 : lo_s[EXP_W-1:0];
                hi_next     = (hi_s > $signed((EXP_W+2)'(EXP_ALL_ONES))) ? EXP_ALL_ONES
                                                                         : hi_s[EXP_W-1:0];
                fmask_next  = {FRAC_W{1'b1}} << (6'd52 - f_eff);
                sum_next    = '0;
                ncnt_next   = '0;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = (left_reg == CNT_W'(1));
                    out_data_next   = {w[63], (clamp_reg && x != '0) ? x_cl : x, w[51:0]};
                    out_center_next = clamp_reg ? center_reg : '0;
                    left_next       = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            ncnt_reg      <= '0;
            sum_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ncnt_reg      <= ncnt_next;
            sum_reg       <= sum_next;
            left_reg      <= left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_reg      <= clamp_next;
        center_reg     <= center_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        fmask_reg      <= fmask_next;
        out_last_reg   <= out_last_next;
        out_data_reg   <= out_data_next;
        out_center_reg <= out_center_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'b00000, out_center_reg, out_data_reg};

`ifndef ASSERT_OFF
    // a closing transaction always leaves the load state
    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        (load_fire && s_tlast) |=> !s_tready)
        else $error("block did not close on tlast");

    // fill count stays inside the row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(BLOCK_CAPACITY))
        else $error("fill count beyond capacity");

    // emission always has elements pending
    a_emit_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (left_reg != '0 && left_reg <= CNT_W'(BLOCK_CAPACITY)))
        else $error("emit with no pending element");

    // the last result of a block carries tlast
    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && left_reg == CNT_W'(1)) |=> (m_tvalid && m_tlast && s_tready))
        else $error("last result not tagged");
`endif

endmodule
`default_nettype wire

### sv/bfq_cell.sv
`default_nettype none
module bfq_cell
    import bfq_pkg::*;
#(
    parameter int W = 64
) (
    input  wire logic         clk,
    input  wire logic         load_en,
    input  wire logic         shift_en,
    input  wire logic [W-1:0] load_data,
    input  wire logic [W-1:0] next_data,
    output logic      [W-1:0] data
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // shift towards the head wins over a load; the two never coincide
    always_comb
    begin
        data_next = data_reg;
        if (shift_en)
        begin
            data_next = next_data;
        end
        else if (load_en)
        begin
            data_next = load_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
`default_nettype wire

### sv/bfq_div.sv
`default_nettype none
module bfq_div
    import bfq_pkg::*;
#(
    parameter int DIVISOR_W = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [SUM_W-1:0]     dividend,
    input  wire logic [DIVISOR_W-1:0] divisor,
    output div_status_t               status
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [STEP_W-1:0]    step_reg,  step_next;
    logic [SUM_W-1:0]     quo_reg,   quo_next;
    logic [DIVISOR_W-1:0] rem_reg,   rem_next;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        logic [DIVISOR_W:0] rem_sh;
        logic               ge;
        rem_sh    = {rem_reg, quo_reg[SUM_W-1]};
        ge        = (rem_sh >= {1'b0, divisor});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            rem_next  = ge ? DIVISOR_W'(rem_sh - {1'b0, divisor}) : rem_sh[DIVISOR_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule
`default_nettype wire

### tb/bfq_checker.sv
`timescale 1ns / 1ps
module bfq_checker
    import bfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [63:0]          s_tdata,   // value_bits
    input  wire logic                 s_tlast,   // block_last
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [79:0]          m_tdata,   // result_bits, center_exponent, zero pad
    input  wire logic                 m_tlast,   // last_out
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output int                        fail_count,
    output int                        pending
);

    localparam int STORE_DEPTH = 64;
    localparam int CAPACITY    = 64;

    typedef struct packed {
        logic [63:0]      word;
        logic [EXP_W-1:0] centre;
        logic             last;
    } quant_result_t;

    logic [3:0]    exp_width;
    logic [5:0]    frac_keep;
    logic [1:0]    centre_mode;
    logic [63:0]   held_words [STORE_DEPTH];
    int            held_count;
    int            exp_sum;
    int            normal_count;
    quant_result_t quantized_due [$];
    quant_result_t want;

    // works out every result of the block just closed, in arrival order
    function automatic void quantize_block();
        int          centre;
        int          k;
        int          half;
        int          lo;
        int          hi;
        int          f;
        int          x;
        bit          clamp;
        logic [51:0] cut_mask;
        logic [63:0] keep;
        logic [63:0] w;
        quant_result_t r;

        centre = 0;
        clamp  = (centre_mode == MODE_AVERAGE) || (centre_mode == MODE_FIXED);
        if (centre_mode == MODE_AVERAGE)
            centre = (normal_count > 0 ? exp_sum / normal_count : 0) + int'(EXP_MIDPOINT);
        else if (centre_mode == MODE_FIXED)
            centre = int'(FIXED_CENTER);

        k    = exp_width < 1 ? 1 : (exp_width > 11 ? 11 : int'(exp_width));
        half = 1 << (k - 1);
        lo   = centre - half;
        hi   = centre + half - 1;
        if (lo < 0)
            lo = 0;
        if (hi > 2047)
            hi = 2047;

        f        = frac_keep > 52 ? 52 : int'(frac_keep);
        cut_mask = {52{1'b1}} << (52 - f);
        keep     = {1'b1, EXP_ALL_ONES, cut_mask};

        for (int i = 0; i < held_count; i++)
        begin
            w = held_words[i % STORE_DEPTH] & keep;
            x = int'(w[62:52]);
            if (clamp && x != 0)
            begin
                if (x > hi)
                    x = hi;
                if (x < lo)
                    x = lo;
                w[62:52] = x[10:0];
            end
            r.word   = w;
            r.centre = clamp ? centre[10:0] : '0;
            r.last   = (i + 1 == held_count);
            quantized_due.push_back(r);
        end

        held_count   = 0;
        exp_sum      = 0;
        normal_count = 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_width    = 4'd8;
            frac_keep    = 6'd23;
            centre_mode  = MODE_AVERAGE;
            held_count   = 0;
            exp_sum      = 0;
            normal_count = 0;
            fail_count   = 0;
            quantized_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EXP_BITS:    exp_width   = cfg_data[3:0];
                    CFG_FRAC_BITS:   frac_keep   = cfg_data[5:0];
                    CFG_CENTER_MODE: centre_mode = cfg_data[1:0];
                    default:         ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                if (held_count < STORE_DEPTH)
                    held_words[held_count] = s_tdata;
                held_count++;
                if (s_tdata[62:52] != '0 && s_tdata[62:52] != EXP_ALL_ONES)
                begin
                    exp_sum += int'(s_tdata[62:52]) - int'(EXP_MIDPOINT);
                    normal_count++;
                end
                if (s_tlast || held_count >= CAPACITY)
                    quantize_block();
            end

            if (m_tvalid && m_tready)
            begin
                if (quantized_due.size() == 0)
                begin
                    $display("%0t: unexpected result, got word %h centre %0d last %0b",
                             $time, m_tdata[63:0], m_tdata[74:64], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = quantized_due.pop_front();
                    if (m_tdata[63:0] !== want.word)
                    begin
                        $display("%0t: result word mismatch, expected %h got %h",
                                 $time, want.word, m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tdata[74:64] !== want.centre)
                    begin
                        $display("%0t: centre mismatch, expected %0d got %0d",
                                 $time, want.centre, m_tdata[74:64]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $display("%0t: last mark mismatch, expected %0b got %0b",
                                 $time, want.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[79:75] !== 5'd0)
                    begin
                        $display("%0t: pad bits mismatch, expected %h got %h",
                                 $time, 5'd0, m_tdata[79:75]);
                        fail_count++;
                    end
                end
            end
        end
        pending = quantized_due.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bfq_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0]           MODE_CUT_ONLY = 2'd2;
    localparam logic [1:0]           MODE_SPARE    = 2'd3;   // decodes as cut only
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;   // no register behind it

    // longest receiver hold-off, long enough for the input side to back up
    localparam int LONG_HOLD  = 200;
    // quiet cycles after the last result: covers the divider overhead
    localparam int QUIET_GAP  = 40;
    localparam int DRAIN_WAIT = 20000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;     // value_bits
    logic                 s_tlast   = 1'b0;   // block_last
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [79:0]          m_tdata;            // result_bits, center_exponent, zero pad
    logic                 m_tlast;            // last_out
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int idle_max      = 3;   // upper bound of the per-transaction gap, both sides
    int hold_requests = 0;   // raised by the stimulus, served by the receiver
    int holds_done    = 0;

    always #10 clk = ~clk;

    block_exponent_float_quantizer_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bfq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // one input transaction: random gap, then hold valid until accepted
    task automatic send_word(input logic [63:0] value, input logic last);
        int gap;

        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
    endtask

    // all three registers plus the spare index, one write per cycle
    task automatic write_config(input logic [5:0] exp_w, input logic [5:0] frac_w,
                                input logic [1:0] mode);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_EXP_BITS;
        cfg_data  <= exp_w;
        @(posedge clk);
        cfg_index <= CFG_FRAC_BITS;
        cfg_data  <= frac_w;
        @(posedge clk);
        cfg_index <= CFG_CENTER_MODE;
        cfg_data  <= {4'b0, mode};
        @(posedge clk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 6'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // wait for every predicted result, then let the divider run out
    task automatic settle();
        int waited;

        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (QUIET_GAP) @(posedge clk);
    endtask

    // a double whose exponent mostly sits near the block's base, with zero,
    // all-ones and extreme exponent fields mixed in
    function automatic logic [63:0] random_word(input int base);
        logic [63:0] w;
        int          e;

        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: ;
            1: w[62:52] = '0;
            2: w[62:52] = EXP_ALL_ONES;
            3: w[62:52] = $urandom_range(0, 1) ? 11'd1 : EXP_ALL_ONES - 11'd1;
            default:
            begin
                e = base + int'($urandom_range(0, 40)) - 20;
                if (e < 1)
                    e = 1;
                if (e > 2046)
                    e = 2046;
                w[62:52] = e[10:0];
            end
        endcase
        return w;
    endfunction

    // short blocks until about n elements have gone in
    task automatic random_blocks(input int n);
        int sent;
        int size;
        int base;

        sent = 0;
        while (sent < n)
        begin
            size = $urandom_range(1, 8);
            base = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 2046))
                                               : int'(EXP_MIDPOINT);
            for (int i = 0; i < size; i++)
                send_word(random_word(base), i == size - 1);
            sent += size;
        end
        stop_sending();
    endtask

    task automatic run_phase(input logic [5:0] exp_w, input logic [5:0] frac_w,
                             input logic [1:0] mode, input int idle, input int n);
        write_config(exp_w, frac_w, mode);
        idle_max = idle;
        random_blocks(n);
        settle();
    endtask

    // receiver: random stall before each transaction, one long hold-off on request
    initial
    begin : receiver
        int gap;

        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                gap = LONG_HOLD;
                holds_done++;
            end
            else
                gap = $urandom_range(0, idle_max);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset defaults: signed zeros, infinity, nan, subnormal,
        // lowest and highest normal exponents, all ones
        send_word(64'h0000_0000_0000_0000, 1'b0);
        send_word(64'h8000_0000_0000_0000, 1'b0);
        send_word(64'h7ff0_0000_0000_0000, 1'b0);
        send_word(64'h7fff_ffff_ffff_ffff, 1'b0);
        send_word(64'h000f_ffff_ffff_ffff, 1'b0);
        send_word(64'h0010_0000_0000_0000, 1'b0);
        send_word(64'h7fef_ffff_ffff_ffff, 1'b0);
        send_word(64'hffff_ffff_ffff_ffff, 1'b1);
        // single-element block
        send_word(64'h3ff0_0000_0000_0000, 1'b1);
        // no counted element: zero and all-ones exponent fields only
        send_word(64'h0000_0000_0000_0001, 1'b0);
        send_word(64'hfff0_0000_0000_0001, 1'b1);
        // negative average that truncates towards zero
        send_word(64'h3fc0_0000_0000_0000, 1'b0);
        send_word(64'hbfd5_5555_5555_5555, 1'b1);
        // far from the bias so the window saturates at the bottom
        send_word(64'h0028_0000_0000_0000, 1'b0);
        send_word(64'h0030_0000_0000_0001, 1'b1);
        stop_sending();
        settle();

        // capacity closes the block without a last mark; the receiver holds off
        // so the row fills and the input side stalls behind it
        write_config(6'd6, 6'd40, MODE_AVERAGE);
        idle_max = 2;
        hold_requests++;
        for (int i = 0; i < 66; i++)
            send_word(random_word(int'(EXP_MIDPOINT)), i == 65);
        stop_sending();
        settle();

        // register sweep: narrowest and widest windows, out-of-range codes,
        // every centre mode, with and without idling
        run_phase(6'd1,  6'd0,  MODE_AVERAGE,  3, 4);
        run_phase(6'd11, 6'd52, MODE_AVERAGE,  0, 4);
        run_phase(6'd0,  6'd63, MODE_FIXED,    3, 4);
        run_phase(6'd15, 6'd53, MODE_CUT_ONLY, 3, 4);
        run_phase(6'd4,  6'd30, MODE_SPARE,    0, 4);
        run_phase(6'd2,  6'd5,  MODE_FIXED,    3, 4);
        run_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)), 3, 4);
        run_phase(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  2'($urandom_range(0, 3)), 1, 4);

        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin : watchdog
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
